/* design/pls_pkg.sv */
// ---------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Command and status codes, field widths and the cell control word.
// ---------------------------------------------------------------------------
package pls_pkg;

   localparam int DATA_W       = 32;
   localparam int CMD_W        = 3;
   localparam int POS_W        = 5;
   localparam int STAT_W       = 2;
   localparam int CNT_OUT_W    = 5;
   localparam int CAPACITY_DEF = 16;

   localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_PREPEND = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_READ    = 3'd3,
      CMD_DELETE  = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast to every cell in the cycle a word is taken
   typedef struct packed {
      logic ins_en;
      logic del_en;
   } cell_ctl_type;

endpackage

/* design/pls_cell.sv */
// ---------------------------------------------------------------------------
// pls_cell: one slot of the list store
// Holds one element; shifts from its left or right neighbor, loads new data
// at the insert position, or holds.
// ---------------------------------------------------------------------------
module pls_cell #(
   parameter int INDEX = 0,
   parameter int CMPW  = 5
) (
   input  logic                                 clock,
   input  pls_pkg::cell_ctl_type                ctl,
   input  logic [CMPW-1:0]                      pos,
   input  logic signed [pls_pkg::DATA_W-1:0]    data_in,
   input  logic signed [pls_pkg::DATA_W-1:0]    left_value,
   input  logic signed [pls_pkg::DATA_W-1:0]    right_value,
   output logic signed [pls_pkg::DATA_W-1:0]    value,
   output logic signed [pls_pkg::DATA_W-1:0]    read_value
);
   import pls_pkg::*;

   localparam logic [CMPW-1:0] MY_IDX = CMPW'(INDEX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     at_pos;
   logic                     above_pos;

   assign at_pos    = (pos == MY_IDX);
   assign above_pos = (MY_IDX > pos);

   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (above_pos) value_in = left_value;
         else if (at_pos) value_in = data_in;
      end else if (ctl.del_en) begin
         // close the gap: everything from the deleted slot up takes its right neighbor
         if (above_pos || at_pos) value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign read_value = at_pos ? value_ff : '0;

endmodule

/* design/positional_list_store.sv */
// ---------------------------------------------------------------------------
// positional_list_store: ordered list with insert and delete at an index
// A row of cells holds the elements in order; inserts shift the cells above
// the position and deletes shift the cells from the position up by one slot.
// ---------------------------------------------------------------------------
// Usage:
//   Request words (req_command, req_position, req_data_in) are taken when
//   req_valid is high and req_stall is low. Commands: append, prepend,
//   insert at position, read at index, delete at index.
//   Each request gives exactly one response word (rsp_data_out, rsp_status,
//   rsp_element_count) taken when rsp_valid is high and rsp_stall is low.
//   The response is registered and shows in the cycle after the request is
//   taken. One command per cycle while req_stall is low; every cell shifts
//   or holds in the same cycle, and the count register is updated in that
//   cycle for the next command.
//   A read selects the addressed cell through an AND-OR tree over the cells.
//   When the receiver stalls, the response holds and req_stall rises; a new
//   request is taken in the same cycle the held response drains.
//   Reset empties the list (count zero) and drops any pending response; the
//   cell contents are left as they are and are never read before written.
// ---------------------------------------------------------------------------
module positional_list_store #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pls_pkg::CMD_W-1:0]            req_command,
   input  logic [pls_pkg::POS_W-1:0]            req_position,
   input  logic signed [pls_pkg::DATA_W-1:0]    req_data_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pls_pkg::DATA_W-1:0]    rsp_data_out,
   output logic [pls_pkg::STAT_W-1:0]           rsp_status,
   output logic [pls_pkg::CNT_OUT_W-1:0]        rsp_element_count
);
   import pls_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [CNT_OUT_W-1:0]     rsp_count_ff;

   logic                     accept;
   logic [CMPW-1:0]          pos_ext;
   logic [CMPW-1:0]          cnt_ext;
   logic [CMPW-1:0]          cell_pos;
   cell_ctl_type             ctl;
   logic                     is_ins;
   logic [CMPW-1:0]          ins_pos;
   logic signed [DATA_W-1:0] data_res;
   status_type               status_res;
   logic signed [DATA_W-1:0] read_data;
   logic [CMPW-1:0]          count_res_ext;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_read  [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign pos_ext   = CMPW'(req_position);
   assign cnt_ext   = CMPW'(count_ff);

   always_comb begin
      read_data = '0;
      for (int i = 0; i < CAPACITY; i++) read_data = read_data | cell_read[i];
   end

   always_comb begin
      is_ins     = 1'b0;
      ins_pos    = pos_ext;
      data_res   = '0;
      status_res = ST_DONE;
      count_in   = count_ff;
      ctl        = '0;
      cell_pos   = pos_ext;
      unique case (req_command)
         CMD_APPEND: begin
            is_ins  = 1'b1;
            ins_pos = cnt_ext;
         end
         CMD_PREPEND: begin
            is_ins  = 1'b1;
            ins_pos = '0;
         end
         CMD_INSERT: begin
            is_ins  = 1'b1;
            ins_pos = pos_ext;
         end
         CMD_READ: begin
            if (pos_ext < cnt_ext) begin
               data_res = read_data;
            end else begin
               data_res   = READ_MISS;
               status_res = ST_RANGE;
            end
         end
         CMD_DELETE: begin
            if (pos_ext < cnt_ext) begin
               ctl.del_en = accept;
               count_in   = CW'(count_ff - 1'b1);
            end else begin
               status_res = ST_RANGE;
            end
         end
         default: ;
      endcase
      if (is_ins) begin
         cell_pos = ins_pos;
         // range check comes before the full check
         if (ins_pos > cnt_ext) begin
            status_res = ST_RANGE;
         end else if (count_ff == FULL_COUNT) begin
            status_res = ST_FULL;
         end else begin
            ctl.ins_en = accept;
            count_in   = CW'(count_ff + 1'b1);
         end
      end
      if (!accept) count_in = count_ff;
   end

   assign count_res_ext = CMPW'(count_in);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      pls_cell #(
         .INDEX (i),
         .CMPW  (CMPW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (cell_pos),
         .data_in     (req_data_in),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i]),
         .read_value  (cell_read[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload loads only with a new word, so a stalled response holds
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= data_res;
         rsp_status_ff <= status_res;
         rsp_count_ff  <= count_res_ext[CNT_OUT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

/* design/pls_checker.sv */
// ---------------------------------------------------------------------------
// pls_checker: port-level checks of the positional list store
// Watches the response channel for held words and consistent status codes.
// ---------------------------------------------------------------------------
module pls_checker #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [pls_pkg::DATA_W-1:0]    rsp_data_out,
   input logic [pls_pkg::STAT_W-1:0]           rsp_status,
   input logic [pls_pkg::CNT_OUT_W-1:0]        rsp_element_count
);
   import pls_pkg::*;

   localparam logic [CNT_OUT_W-1:0] FULL_LOW = CNT_OUT_W'(CAPACITY);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_element_count))
      else $error("response changed while stalled");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a full status only comes from a full store
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_element_count == FULL_LOW
         && rsp_data_out == 0)
      else $error("full status with a count below capacity");

   // an out-of-range word carries -1 (read) or 0 (insert, delete)
   a_range_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RANGE |-> rsp_data_out == READ_MISS
         || rsp_data_out == 0)
      else $error("bad data on an out-of-range response");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (.*);

/* tb/list_store_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// list_store_checker: response predictor and scoreboard for the list store
// Watches the request and response channels. Every accepted request word is
// run through a private copy of the list to work out its response word,
// and every accepted response word is compared with the oldest one waiting.
// ---------------------------------------------------------------------------
module list_store_checker
   import pls_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_data_in,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_data_out,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic [CNT_OUT_W-1:0]     rsp_element_count,
   output int                       fail_count,
   output int                       pending_count,
   output int                       compared_count
);

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic [CNT_OUT_W-1:0]     count;
   } rsp_word_type;

   logic signed [DATA_W-1:0] list_cells [CAPACITY];
   int                       cell_count;
   rsp_word_type             awaited_rsp [$];
   int                       errors_seen;
   int                       rsp_compared;

   // shift the tail up one slot and drop the value in at the position
   function automatic status_type place_value(int at, logic signed [DATA_W-1:0] value);
      if (at > cell_count) return ST_RANGE;
      if (cell_count >= CAPACITY) return ST_FULL;
      for (int i = cell_count; i > at; i--) list_cells[i] = list_cells[i-1];
      list_cells[at] = value;
      cell_count++;
      return ST_DONE;
   endfunction

   function automatic rsp_word_type predict_response(logic [CMD_W-1:0] cmd,
                                                     logic [POS_W-1:0] pos,
                                                     logic signed [DATA_W-1:0] value);
      rsp_word_type w;
      w.data   = '0;
      w.status = ST_DONE;
      case (cmd)
         CMD_APPEND:  w.status = place_value(cell_count, value);
         CMD_PREPEND: w.status = place_value(0, value);
         CMD_INSERT:  w.status = place_value(int'(pos), value);
         CMD_READ: begin
            if (int'(pos) < cell_count) begin
               w.data = list_cells[pos];
            end else begin
               w.data   = READ_MISS;
               w.status = ST_RANGE;
            end
         end
         CMD_DELETE: begin
            if (int'(pos) < cell_count) begin
               for (int i = int'(pos); i + 1 < cell_count; i++) list_cells[i] = list_cells[i+1];
               cell_count--;
            end else begin
               w.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      w.count = CNT_OUT_W'(cell_count);
      return w;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_word_type exp_word;
      if (reset) begin
         awaited_rsp.delete();
         cell_count   = 0;
         errors_seen  = 0;
         rsp_compared = 0;
      end else begin
         // the response taken at this edge belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $error("response word with nothing outstanding: data_out %0d status %0d count %0d",
                      rsp_data_out, rsp_status, rsp_element_count);
               errors_seen++;
            end else begin
               exp_word = awaited_rsp.pop_front();
               rsp_compared++;
               if (rsp_data_out !== exp_word.data) begin
                  $error("data_out: expected %0d, got %0d", exp_word.data, rsp_data_out);
                  errors_seen++;
               end
               if (rsp_status !== exp_word.status) begin
                  $error("status: expected %0d, got %0d", exp_word.status, rsp_status);
                  errors_seen++;
               end
               if (rsp_element_count !== exp_word.count) begin
                  $error("element_count: expected %0d, got %0d",
                         exp_word.count, rsp_element_count);
                  errors_seen++;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(predict_response(req_command, req_position, req_data_in));
      end
      fail_count     <= errors_seen;
      pending_count  <= awaited_rsp.size();
      compared_count <= rsp_compared;
   end

endmodule

/* tb/tb_positional_list_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_positional_list_store: testbench top for the positional list store
// Drives a directed opening, then random command streams that swing the
// list between empty and full, with bursty idling on both channels and one
// long response hold-off; the checker beside the block scores every word.
// ---------------------------------------------------------------------------
module tb_positional_list_store;
   import pls_pkg::*;

   localparam int CAP         = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 1450;
   localparam int SEGMENTS    = 12;
   localparam int HOLD_CYCLES = 90;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [STAT_W-1:0]        rsp_status;
   logic [CNT_OUT_W-1:0]     rsp_element_count;

   int fail_count;
   int pending_count;
   int compared_count;

   // stimulus bookkeeping: length of the list as the block will see it
   int list_len = 0;
   int words_sent = 0;
   int full_hits = 0;
   int range_hits = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off_req = 1'b0;

   positional_list_store #(.CAPACITY(CAP)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_position      (req_position),
      .req_data_in       (req_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   list_store_checker #(.CAPACITY(CAP)) scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_position      (req_position),
      .req_data_in       (req_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .compared_count    (compared_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_positional_list_store: errors");
      $finish;
   end

   // response side: random stall bursts, plus the long hold-off on request
   initial begin : drain_responses
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off_req = 1'b0;
         end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic issue_word(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic signed [DATA_W-1:0] d);
      int gap;
      gap = 0;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
         gap = $urandom_range(1, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= c;
      req_position <= p;
      req_data_in  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // track the length so random positions land in range most of the time
      case (c)
         CMD_APPEND, CMD_PREPEND: begin
            if (list_len < CAP) list_len++;
            else full_hits++;
         end
         CMD_INSERT: begin
            if (int'(p) > list_len) range_hits++;
            else if (list_len < CAP) list_len++;
            else full_hits++;
         end
         CMD_READ:   if (int'(p) >= list_len) range_hits++;
         CMD_DELETE: begin
            if (int'(p) < list_len) list_len--;
            else range_hits++;
         end
         default: ;
      endcase
      if (c <= CMD_DELETE) words_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed commands; grow_pct biases toward insert over delete
   task automatic send_random(input int grow_pct);
      int r;
      int lo;
      logic [CMD_W-1:0] c;
      logic [POS_W-1:0] p;
      r = $urandom_range(0, 99);
      if (r < 3) c = CMD_W'($urandom_range(5, 7));
      else if (r < 23) c = CMD_READ;
      else if ($urandom_range(0, 99) < grow_pct) begin
         case ($urandom_range(0, 2))
            0: c = CMD_APPEND;
            1: c = CMD_PREPEND;
            default: c = CMD_INSERT;
         endcase
      end else c = CMD_DELETE;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         p = POS_W'($urandom);
      end else if (r < 18) begin
         lo = (c == CMD_INSERT) ? list_len + 1 : list_len;
         p = POS_W'($urandom_range(lo, 31));
      end else if (c == CMD_INSERT) begin
         p = POS_W'($urandom_range(0, list_len));
      end else begin
         p = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : POS_W'($urandom);
      end
      issue_word(c, p, pick_value());
   endtask

   initial begin : make_stimulus
      int grow_pct;
      int target;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening on an empty list
      issue_word(CMD_READ,    5'd0,  32'sd0);
      issue_word(CMD_DELETE,  5'd0,  32'sd0);
      issue_word(CMD_INSERT,  5'd1,  32'sd7);
      issue_word(CMD_INSERT,  5'd31, -32'sd1);
      issue_word(CMD_APPEND,  5'd0,  32'sh7fff_ffff);
      issue_word(CMD_PREPEND, 5'd31, 32'sh8000_0000);
      issue_word(CMD_INSERT,  5'd1,  32'sd0);
      issue_word(CMD_INSERT,  5'd3,  -32'sd1);
      issue_word(CMD_INSERT,  5'd2,  32'sh5555_5555);
      for (int i = 0; i < 5; i++) issue_word(CMD_READ, POS_W'(i), 32'sd0);
      issue_word(CMD_READ,    5'd5,  32'sd0);
      issue_word(CMD_READ,    5'd31, 32'sd0);
      issue_word(CMD_DELETE,  5'd4,  32'sd0);
      issue_word(CMD_DELETE,  5'd1,  32'sd0);
      issue_word(CMD_DELETE,  5'd2,  32'sd0);
      // two elements left: delete at the head must remove only one
      issue_word(CMD_DELETE,  5'd0,  32'sd0);
      issue_word(CMD_READ,    5'd0,  32'sd0);
      issue_word(CMD_READ,    5'd1,  32'sd0);
      issue_word(CMD_W'(5),   5'd0,  32'sd0);
      issue_word(CMD_W'(7),   5'd16, 32'shaaaa_aaaa);
      issue_word(CMD_DELETE,  5'd0,  32'sd0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 3)
            0: grow_pct = 80;
            1: grow_pct = 20;
            default: grow_pct = 50;
         endcase
         if (seg == SEGMENTS - 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (seg == 2) begin
            // keep offering while the receiver holds off so the block backs up
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_off_req  = 1'b1;
         end else begin
            send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
         end
         target = words_sent + RANDOM_ITEMS / SEGMENTS;
         while (words_sent < target) send_random(grow_pct);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("%0d commands sent, %0d hit a full list, %0d were out of range",
               words_sent, full_hits, range_hits);
      $display("%0d response words compared", compared_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_positional_list_store: clean");
      end else begin
         $display("tb_positional_list_store: errors");
      end
      $finish;
   end

endmodule
